// ----- rtl/core/tgcs_pkg.sv -----
// Package: shared widths, constants and types of the trajectory grid cell segmenter.
`default_nettype none
package tgcs_pkg;

	localparam int unsigned MAX_POINTS    = 1048576;
	localparam int unsigned MAX_GRID_SIDE = 4096;

	localparam int unsigned TID_W   = 24;
	localparam int unsigned COORD_W = 32;
	localparam int unsigned SIZE_W  = 31;
	localparam int unsigned SIDE_W  = 13;
	localparam int unsigned CELL_W  = 24;
	localparam int unsigned IDX_W   = 20;
	localparam int unsigned CNT_W   = 21;
	localparam int unsigned QUO_W   = 12;

	localparam int unsigned IN_W    = 88;
	localparam int unsigned OUT_W   = 112;
	localparam int unsigned CFG_IDX_W = 3;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_POINTS - 1);
	localparam logic [SIDE_W-1:0] SIDE_MAX = SIDE_W'(MAX_GRID_SIDE);

	localparam logic [CFG_IDX_W-1:0] REG_X_ORIGIN = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_Y_TOP    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CELL     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COLUMNS  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ROWS     = 3'd4;

	typedef struct packed {
		logic signed [COORD_W-1:0] x_origin;
		logic signed [COORD_W-1:0] y_top;
		logic [SIZE_W-1:0]         side_len;
		logic [SIDE_W-1:0]         columns;
		logic [SIDE_W-1:0]         rows;
	} grid_cfg_t;

	typedef struct packed {
		logic [TID_W-1:0]  tid;
		logic [CELL_W-1:0] grid_idx;
		logic              fin;
	} point_cls_t;

	typedef struct packed {
		logic [TID_W-1:0]  traj;
		logic [CELL_W-1:0] grid_idx;
		logic [IDX_W-1:0]  first;
		logic [IDX_W-1:0]  final_idx;
		logic [CNT_W-1:0]  points;
		logic              last;
	} rec_t;

endpackage
`default_nettype wire

// ----- rtl/core/tgcs_div.sv -----
// Iterative divider: clamped floor quotient of one grid axis, one quotient bit a cycle.
`default_nettype none
module tgcs_div
	import tgcs_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [COORD_W:0]    diff,
	input  wire logic [SIZE_W-1:0]   divisor,
	input  wire logic [SIDE_W-1:0]   limit,
	output logic                     done,
	output logic [QUO_W-1:0]         quo
);

	localparam int unsigned WIDE_W = SIZE_W + QUO_W;
	localparam logic [3:0] TOP_STEP = 4'(QUO_W - 1);

	logic               busy_q;
	logic               done_q;
	logic [3:0]         step_q;
	logic [COORD_W-1:0] rem_q;
	logic [SIZE_W-1:0]  dvs_q;
	logic [QUO_W-1:0]   quo_q;
	logic               neg_q;
	logic               over_q;

	logic [WIDE_W-1:0]  shifted;
	logic [WIDE_W-1:0]  rem_wide;
	logic [WIDE_W-1:0]  full_scale;
	logic [QUO_W-1:0]   lim_m1;

	assign shifted    = WIDE_W'(dvs_q) << step_q;
	assign rem_wide   = WIDE_W'(rem_q);
	assign full_scale = {divisor, {QUO_W{1'b0}}};
	assign lim_m1     = QUO_W'(limit - SIDE_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= TOP_STEP;
			end else if (busy_q) begin
				if (step_q == 4'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q - 4'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= diff[COORD_W-1:0];
			dvs_q  <= divisor;
			quo_q  <= '0;
			neg_q  <= diff[COORD_W];
			over_q <= WIDE_W'(diff[COORD_W-1:0]) >= full_scale;
		end else if (busy_q) begin
			if (rem_wide >= shifted) begin
				rem_q         <= COORD_W'(rem_wide - shifted);
				quo_q[step_q] <= 1'b1;
			end
		end
	end

	always_comb begin
		if (neg_q) begin
			quo = '0;
		end else if (over_q || (quo_q > lim_m1)) begin
			quo = lim_m1;
		end else begin
			quo = quo_q;
		end
	end

	assign done = done_q;

endmodule
`default_nettype wire

// ----- rtl/core/tgcs_front.sv -----
// Front end: accepts points, maps each to its grid cell and queues the result.
`default_nettype none
module tgcs_front
	import tgcs_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire grid_cfg_t        cfg,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [IN_W-1:0]  in_data,
	input  wire logic             in_last,
	output logic                  push,
	output point_cls_t            push_data,
	input  wire logic             full
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_PUSH
	} front_state_t;

	front_state_t      state_q;
	logic [TID_W-1:0]  tid_q;
	logic              fin_q;

	logic signed [COORD_W-1:0] lon;
	logic signed [COORD_W-1:0] lat;
	logic [COORD_W:0]          diff_x;
	logic [COORD_W:0]          diff_y;
	logic                      start;
	logic                      done_x;
	logic                      done_y;
	logic [QUO_W-1:0]          col;
	logic [QUO_W-1:0]          row;
	logic [CELL_W:0]           cell_full;

	assign lon    = in_data[TID_W +: COORD_W];
	assign lat    = in_data[TID_W+COORD_W +: COORD_W];
	assign diff_x = {lon[COORD_W-1], lon} - {cfg.x_origin[COORD_W-1], cfg.x_origin};
	assign diff_y = {cfg.y_top[COORD_W-1], cfg.y_top} - {lat[COORD_W-1], lat};

	assign in_ready = (state_q == ST_IDLE);
	assign start    = in_valid && in_ready;

	tgcs_div u_div_x (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.diff    (diff_x),
		.divisor (cfg.side_len),
		.limit   (cfg.columns),
		.done    (done_x),
		.quo     (col)
	);

	tgcs_div u_div_y (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.diff    (diff_y),
		.divisor (cfg.side_len),
		.limit   (cfg.rows),
		.done    (done_y),
		.quo     (row)
	);

	assign cell_full = (CELL_W+1)'(row) * (CELL_W+1)'(cfg.columns) + (CELL_W+1)'(col);

	assign push               = (state_q == ST_PUSH) && !full;
	assign push_data.tid      = tid_q;
	assign push_data.grid_idx = cell_full[CELL_W-1:0];
	assign push_data.fin      = fin_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (done_x && done_y) state_q <= ST_PUSH;
				end
				ST_PUSH: begin
					if (!full) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			tid_q <= in_data[TID_W-1:0];
			fin_q <= in_last;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/tgcs_queue.sv -----
// Four-entry queue of classified points between front and back end.
`default_nettype none
module tgcs_queue
	import tgcs_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  wire point_cls_t wdata,
	output logic            full,
	input  wire logic       pop,
	output logic            valid,
	output point_cls_t      rdata
);

	localparam int unsigned DEPTH = 4;
	localparam int unsigned PTR_W = $clog2(DEPTH);

	point_cls_t       mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign full  = (count_q == (PTR_W+1)'(DEPTH));
	assign valid = (count_q != '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (pop)  rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			if (push && !pop) begin
				count_q <= count_q + (PTR_W+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (PTR_W+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wdata;
	end

endmodule
`default_nettype wire

// ----- rtl/core/tgcs_back.sv -----
// Back end: run tracking per trajectory and record output with a second-record slot.
`default_nettype none
module tgcs_back
	import tgcs_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              q_valid,
	input  wire point_cls_t        q_data,
	output logic                   pop,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output rec_t                   out_rec
);

	logic [IDX_W-1:0]  pc_q;
	logic [IDX_W-1:0]  rs_q;
	logic [CELL_W-1:0] rc_q;
	logic              out_v_q;
	rec_t              out_q;
	logic              pend_v_q;
	rec_t              pend_q;

	logic              fin;
	logic [IDX_W-1:0]  rs;
	logic [CELL_W-1:0] rc;
	logic              same;
	logic [CNT_W-1:0]  span;
	rec_t              rec0;
	rec_t              rec1;
	logic              emit;
	logic              two;

	assign pop = q_valid && !pend_v_q && (!out_v_q || out_ready);

	always_comb begin
		fin  = q_data.fin || (pc_q == LAST_IDX);
		rs   = (pc_q == '0) ? '0 : rs_q;
		rc   = (pc_q == '0) ? q_data.grid_idx : rc_q;
		same = (q_data.grid_idx == rc);
		span = {1'b0, pc_q} - {1'b0, rs};
		emit = fin || !same;
		two  = fin && !same;

		rec0.traj      = q_data.tid;
		rec0.grid_idx  = rc;
		rec0.first     = rs;
		rec0.final_idx = same ? pc_q : pc_q - IDX_W'(1);
		rec0.points    = same ? span + CNT_W'(1) : span;
		rec0.last      = !two;

		rec1.traj      = q_data.tid;
		rec1.grid_idx  = q_data.grid_idx;
		rec1.first     = pc_q;
		rec1.final_idx = pc_q;
		rec1.points    = CNT_W'(1);
		rec1.last      = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q     <= '0;
			rs_q     <= '0;
			rc_q     <= '0;
			out_v_q  <= 1'b0;
			pend_v_q <= 1'b0;
		end else begin
			if (pop) begin
				if (fin) begin
					pc_q <= '0;
					rs_q <= '0;
					rc_q <= '0;
				end else begin
					pc_q <= pc_q + IDX_W'(1);
					rs_q <= same ? rs : pc_q;
					rc_q <= q_data.grid_idx;
				end
				out_v_q  <= emit;
				pend_v_q <= two;
			end else if (!out_v_q || out_ready) begin
				out_v_q  <= pend_v_q;
				pend_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q  <= rec0;
			pend_q <= rec1;
		end else if ((!out_v_q || out_ready) && pend_v_q) begin
			out_q <= pend_q;
		end
	end

	assign out_valid = out_v_q;
	assign out_rec   = out_q;

endmodule
`default_nettype wire

// ----- rtl/core/trajectory_grid_cell_segmenter.sv -----
// Top level: configuration registers, front end, point queue and back end.
// Points are taken one at a time: the next waits until the 12-step axis
// dividers finish and the last point's cell is queued.
// A final point that lands in a new cell gives two record beats.
// Reset (arst_n, asynchronous, active low) clears run state, queue, handshakes
// and sets the grid registers to origin 0, cell size 1, one column, one row.
`default_nettype none
module trajectory_grid_cell_segmenter
	import tgcs_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// trajectory_id[23:0], longitude[55:24], latitude[87:56]
	input  wire logic [IN_W-1:0]       s_tdata,
	input  wire logic                  s_tlast,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// record_trajectory[23:0], cell_index[47:24], first_index[67:48],
	// final_index[87:68], run_points[108:88], zero pad[111:109]
	output logic [OUT_W-1:0]           m_tdata,
	output logic                       m_tlast,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [COORD_W-1:0]    cfg_data
);

	grid_cfg_t  cfg_q;
	logic       push;
	point_cls_t push_data;
	logic       full;
	logic       pop;
	logic       q_valid;
	point_cls_t q_data;
	rec_t       rec;

	logic [SIZE_W-1:0] wr_size;
	logic [SIDE_W-1:0] wr_side;

	assign cfg_ready = 1'b1;
	assign wr_size   = (cfg_data[SIZE_W-1:0] == '0) ? SIZE_W'(1) : cfg_data[SIZE_W-1:0];

	always_comb begin
		if (cfg_data[SIDE_W-1:0] == '0) begin
			wr_side = SIDE_W'(1);
		end else if (cfg_data[SIDE_W-1:0] > SIDE_MAX) begin
			wr_side = SIDE_MAX;
		end else begin
			wr_side = cfg_data[SIDE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.x_origin <= '0;
			cfg_q.y_top    <= '0;
			cfg_q.side_len <= SIZE_W'(1);
			cfg_q.columns  <= SIDE_W'(1);
			cfg_q.rows     <= SIDE_W'(1);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_X_ORIGIN: cfg_q.x_origin <= cfg_data;
				REG_Y_TOP:    cfg_q.y_top    <= cfg_data;
				REG_CELL:     cfg_q.side_len <= wr_size;
				REG_COLUMNS:  cfg_q.columns  <= wr_side;
				REG_ROWS:     cfg_q.rows     <= wr_side;
				default: ;
			endcase
		end
	end

	tgcs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_data   (s_tdata),
		.in_last   (s_tlast),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	tgcs_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_data),
		.full   (full),
		.pop    (pop),
		.valid  (q_valid),
		.rdata  (q_data)
	);

	tgcs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_data    (q_data),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_rec   (rec)
	);

	assign m_tdata = {3'b000, rec.points, rec.final_idx, rec.first, rec.grid_idx, rec.traj};
	assign m_tlast = rec.last;

endmodule
`default_nettype wire

// ----- tb/trajectory_grid_cell_segmenter_checker.sv -----
// Checker for the trajectory grid cell segmenter: predicts run records from observed beats.
module trajectory_grid_cell_segmenter_checker
	import tgcs_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	input  wire logic                 s_tready,
	// trajectory_id[23:0], longitude[55:24], latitude[87:56]
	input  wire logic [IN_W-1:0]      s_tdata,
	input  wire logic                 s_tlast,
	input  wire logic                 m_tvalid,
	input  wire logic                 m_tready,
	// record_trajectory[23:0], cell_index[47:24], first_index[67:48],
	// final_index[87:68], run_points[108:88], zero pad[111:109]
	input  wire logic [OUT_W-1:0]     m_tdata,
	input  wire logic                 m_tlast,
	input  wire logic                 cfg_valid,
	input  wire logic                 cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [COORD_W-1:0]   cfg_data,
	output int                        errors,
	output int                        pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned OFS_CELL  = TID_W;
	localparam int unsigned OFS_FIRST = OFS_CELL + CELL_W;
	localparam int unsigned OFS_FINAL = OFS_FIRST + IDX_W;
	localparam int unsigned OFS_COUNT = OFS_FINAL + IDX_W;

	typedef struct packed {
		logic [TID_W-1:0]  traj;
		logic [CELL_W-1:0] cell_no;
		logic [IDX_W-1:0]  first;
		logic [IDX_W-1:0]  final_idx;
		logic [CNT_W-1:0]  points;
		logic              closing;
	} run_record_t;

	logic signed [COORD_W-1:0] x_origin;
	logic signed [COORD_W-1:0] y_top;
	logic [SIZE_W-1:0]         side_len;
	logic [SIDE_W-1:0]         columns;
	logic [SIDE_W-1:0]         rows;
	logic [IDX_W-1:0]          point_count;
	logic [IDX_W-1:0]          run_first;
	logic [CELL_W-1:0]         run_cell;
	run_record_t               due_records[$];

	function automatic longint side_limit(logic [SIDE_W-1:0] n);
		if (n == 0)
			return 1;
		if (n > SIDE_MAX)
			return longint'(SIDE_MAX);
		return longint'(n);
	endfunction

	// floor division clamped to the grid edge
	function automatic longint axis_cell(longint diff, longint size, longint lim);
		longint q;
		if (diff < 0)
			return 0;
		q = diff / size;
		return (q > lim - 1) ? lim - 1 : q;
	endfunction

	function automatic logic [CELL_W-1:0] cell_of(logic signed [COORD_W-1:0] lon,
		logic signed [COORD_W-1:0] lat);
		longint size, cols, row, col;
		size = (side_len == 0) ? 64'sd1 : longint'(side_len);
		cols = side_limit(columns);
		row  = axis_cell(longint'(y_top) - longint'(lat), size, side_limit(rows));
		col  = axis_cell(longint'(lon) - longint'(x_origin), size, cols);
		return CELL_W'(row * cols + col);
	endfunction

	task automatic push_record(input logic [TID_W-1:0] tid, input logic [CELL_W-1:0] cell_no,
		input logic [IDX_W-1:0] first, input logic [IDX_W-1:0] final_idx,
		input logic [CNT_W-1:0] points, input logic closing);
		run_record_t rec;
		rec.traj      = tid;
		rec.cell_no   = cell_no;
		rec.first     = first;
		rec.final_idx = final_idx;
		rec.points    = points;
		rec.closing   = closing;
		due_records.insert(due_records.size(), rec);
	endtask

	task automatic segment_point(input logic [TID_W-1:0] tid,
		input logic signed [COORD_W-1:0] lon, input logic signed [COORD_W-1:0] lat,
		input logic fin_in);
		logic [CELL_W-1:0] cell_no;
		logic [IDX_W-1:0]  i;
		logic              fin;
		cell_no = cell_of(lon, lat);
		i       = point_count;
		// an over-long trajectory is cut at the last index
		fin     = fin_in || (i >= LAST_IDX);
		if (i == 0) begin
			run_cell  = cell_no;
			run_first = '0;
		end
		if (fin) begin
			if (cell_no == run_cell) begin
				push_record(tid, cell_no, run_first, i,
					CNT_W'(i) - CNT_W'(run_first) + CNT_W'(1), 1'b1);
			end else begin
				push_record(tid, run_cell, run_first, i - 1'b1,
					CNT_W'(i) - CNT_W'(run_first), 1'b0);
				push_record(tid, cell_no, i, i, CNT_W'(1), 1'b1);
			end
			point_count = '0;
			run_first   = '0;
			run_cell    = '0;
		end else begin
			if (cell_no != run_cell) begin
				push_record(tid, run_cell, run_first, i - 1'b1,
					CNT_W'(i) - CNT_W'(run_first), 1'b1);
				run_cell  = cell_no;
				run_first = i;
			end
			point_count = i + 1'b1;
		end
	endtask

	task automatic flag_mismatch(input string what);
		$display("[%0t] record check failed: %s", $time, what);
		errors++;
	endtask

	task automatic check_field(input string name, input longint got, input longint want);
		if (got != want)
			flag_mismatch($sformatf("%s got %0d want %0d", name, got, want));
	endtask

	task automatic check_record();
		run_record_t want;
		if (due_records.size() == 0) begin
			flag_mismatch("record beat with no record due");
			return;
		end
		want = due_records.pop_front();
		check_field("record_trajectory", m_tdata[TID_W-1:0], want.traj);
		check_field("cell_index", m_tdata[OFS_CELL +: CELL_W], want.cell_no);
		check_field("first_index", m_tdata[OFS_FIRST +: IDX_W], want.first);
		check_field("final_index", m_tdata[OFS_FINAL +: IDX_W], want.final_idx);
		check_field("run_points", m_tdata[OFS_COUNT +: CNT_W], want.points);
		check_field("last_of_burst", m_tlast, want.closing);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_origin    = '0;
			y_top       = '0;
			side_len    = SIZE_W'(1);
			columns     = SIDE_W'(1);
			rows        = SIDE_W'(1);
			point_count = '0;
			run_first   = '0;
			run_cell    = '0;
			errors      = 0;
			due_records.delete();
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_X_ORIGIN: x_origin = cfg_data;
					REG_Y_TOP: y_top = cfg_data;
					REG_CELL: side_len = cfg_data[SIZE_W-1:0];
					REG_COLUMNS: columns = cfg_data[SIDE_W-1:0];
					REG_ROWS: rows = cfg_data[SIDE_W-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				segment_point(s_tdata[TID_W-1:0], s_tdata[TID_W +: COORD_W],
					s_tdata[TID_W+COORD_W +: COORD_W], s_tlast);
			if (m_tvalid && m_tready)
				check_record();
			pending <= due_records.size();
		end
	end

endmodule

// ----- tb/trajectory_grid_cell_segmenter_tb.sv -----
// Testbench top: drives points, grid settings and back-pressure into the segmenter.
module trajectory_grid_cell_segmenter_tb
	import tgcs_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT_CYCLES  = 500000;
	localparam int DRAIN_CYCLES  = 64;
	localparam int LONG_HOLD     = 1500;
	localparam int RANDOM_PHASES = 5;
	localparam int PHASE_ITEMS   = 150;

	// first index past the register list
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd5;
	localparam logic [COORD_W-1:0]   COORD_MIN = 32'h8000_0000;
	localparam logic [COORD_W-1:0]   COORD_MAX = 32'h7FFF_FFFF;
	localparam logic [TID_W-1:0]     TID_MAX   = 24'hFF_FFFF;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	// trajectory_id[23:0], longitude[55:24], latitude[87:56]
	logic [IN_W-1:0]      s_tdata;
	logic                 s_tlast;
	logic                 m_tvalid;
	logic                 m_tready;
	// record_trajectory[23:0], cell_index[47:24], first_index[67:48],
	// final_index[87:68], run_points[108:88], zero pad[111:109]
	logic [OUT_W-1:0]     m_tdata;
	logic                 m_tlast;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [COORD_W-1:0]   cfg_data;

	int     errors;
	int     pending;
	int     cycles = 0;
	int     hold_seq;
	int     burst_left;
	longint cur_xo, cur_yt, cur_size, cur_cols, cur_rows;

	trajectory_grid_cell_segmenter u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	trajectory_grid_cell_segmenter_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.errors    (errors),
		.pending   (pending)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// record sink: changing ready patterns, plus a long hold-off on request
	initial begin : record_sink
		int hold_seen, mode, cnt;
		hold_seen = 0;
		mode      = 0;
		cnt       = 0;
		m_tready  = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_seq != hold_seen) begin
				hold_seen = hold_seq;
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end
			if (cnt == 0) begin
				mode = $urandom_range(0, 3);
				cnt  = $urandom_range(20, 200);
			end
			cnt--;
			case (mode)
				0: m_tready <= 1'b1;
				1: m_tready <= ($urandom_range(0, 1) == 1);
				2: m_tready <= (cnt % 4 != 0);
				default: m_tready <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	task automatic drain();
		s_tvalid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic send_point(input logic [TID_W-1:0] tid, input logic [COORD_W-1:0] lon,
		input logic [COORD_W-1:0] lat, input logic fin);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 10);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= {lat, lon, tid};
		s_tlast  <= fin;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic load_grid(input logic [COORD_W-1:0] xo, input logic [COORD_W-1:0] yt,
		input logic [COORD_W-1:0] size, input logic [COORD_W-1:0] cols,
		input logic [COORD_W-1:0] rows);
		logic [CFG_IDX_W-1:0] idx_q[$];
		logic [COORD_W-1:0]   val_q[$];
		drain();
		idx_q = '{REG_X_ORIGIN, REG_Y_TOP, REG_CELL, REG_COLUMNS, REG_ROWS,
			CFG_IDX_W'($urandom_range(2**CFG_IDX_W - 1, REG_SPARE))};
		val_q = '{xo, yt, size, cols, rows, COORD_W'($urandom)};
		cfg_valid <= 1'b1;
		foreach (idx_q[k]) begin
			cfg_index <= idx_q[k];
			cfg_data  <= val_q[k];
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
		end
		cfg_valid <= 1'b0;
		cur_xo   = longint'($signed(xo));
		cur_yt   = longint'($signed(yt));
		cur_size = (size[SIZE_W-1:0] == 0) ? 1 : longint'(size[SIZE_W-1:0]);
		cur_cols = (cols[SIDE_W-1:0] == 0) ? 1 : longint'(cols[SIDE_W-1:0]);
		cur_rows = (rows[SIDE_W-1:0] == 0) ? 1 : longint'(rows[SIDE_W-1:0]);
		if (cur_cols > MAX_GRID_SIDE) cur_cols = MAX_GRID_SIDE;
		if (cur_rows > MAX_GRID_SIDE) cur_rows = MAX_GRID_SIDE;
	endtask

	// random walk over the grid, mostly closed by a final point
	task automatic drive_trajectory(inout int sent);
		logic [TID_W-1:0] tid;
		longint           cx, cy, lon, lat;
		int               len;
		bit               closed;
		tid    = TID_W'($urandom);
		len    = $urandom_range(1, 24);
		closed = ($urandom_range(0, 9) != 0);
		cx     = longint'($urandom_range(0, cur_cols + 1)) - 1;
		cy     = longint'($urandom_range(0, cur_rows + 1)) - 1;
		for (int k = 0; k < len; k++) begin
			if ($urandom_range(0, 19) == 0)
				tid = TID_W'($urandom);
			lon = cur_xo + cx * cur_size + longint'($urandom_range(0, cur_size - 1));
			lat = cur_yt - cy * cur_size - longint'($urandom_range(0, cur_size - 1));
			send_point(tid, lon[COORD_W-1:0], lat[COORD_W-1:0], closed && (k == len - 1));
			sent++;
			if ($urandom_range(0, 2) == 0) begin
				cx += longint'($urandom_range(0, 2)) - 1;
				cy += longint'($urandom_range(0, 2)) - 1;
			end
		end
	endtask

	task automatic random_phase(input bit with_hold);
		int                 sent;
		logic [COORD_W-1:0] xo, yt, size_v, cols_v, rows_v;
		xo = ($urandom_range(0, 3) == 0) ? COORD_W'($urandom)
			: COORD_W'($urandom_range(0, 32'h8000_0000)) - 32'h4000_0000;
		yt = ($urandom_range(0, 3) == 0) ? COORD_W'($urandom)
			: COORD_W'($urandom_range(0, 32'h8000_0000)) - 32'h4000_0000;
		case ($urandom_range(0, 5))
			0: size_v = '0;
			1: size_v = COORD_W'($urandom);
			default: size_v = COORD_W'($urandom_range(1, 5000));
		endcase
		cols_v = ($urandom_range(0, 5) == 0) ? COORD_W'($urandom)
			: COORD_W'($urandom_range(1, 40));
		rows_v = ($urandom_range(0, 5) == 0) ? COORD_W'($urandom)
			: COORD_W'($urandom_range(1, 40));
		load_grid(xo, yt, size_v, cols_v, rows_v);
		if (with_hold)
			hold_seq <= hold_seq + 1;
		sent = 0;
		while (sent < PHASE_ITEMS) begin
			if ($urandom_range(0, 6) == 0) begin
				send_point(TID_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
					$urandom_range(0, 3) == 0);
				sent++;
			end else begin
				drive_trajectory(sent);
			end
		end
	endtask

	initial begin : stimulus
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tlast    = 1'b0;
		cfg_valid  = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		hold_seq   = 0;
		burst_left = 0;
		cur_xo     = 0;
		cur_yt     = 0;
		cur_size   = 1;
		cur_cols   = 1;
		cur_rows   = 1;
		arst_n     = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// reset grid is a single cell
		send_point('0, '0, '0, 1'b0);
		send_point('0, COORD_MAX, COORD_MIN, 1'b1);

		// 20 x 20 grid of 100-unit cells
		load_grid(-1000, 1000, 100, 20, 20);
		send_point(TID_MAX, -1000, 1000, 1'b1);
		send_point(24'd1, -950, 950, 1'b0);
		send_point(24'd1, -950, 950, 1'b0);
		send_point(24'd1, -850, 950, 1'b0);
		send_point(24'd1, -850, 850, 1'b0);
		send_point(24'd1, -850, 850, 1'b1);
		// final point in a new cell, far corner clamped
		send_point(24'd2, 0, 0, 1'b0);
		send_point(24'd2, COORD_MAX, COORD_MIN, 1'b1);
		// outside top-left, then id change without a final point
		send_point(24'd3, COORD_MIN, COORD_MAX, 1'b0);
		send_point(24'd4, -750, 1000, 1'b0);
		send_point(24'd4, -1001, 1001, 1'b1);

		// zero cell size and columns, oversized rows, extreme corner
		load_grid(COORD_MIN, COORD_MAX, 32'h8000_0000, 32'h0000_2000, 32'h0000_1FFF);
		send_point(24'd5, COORD_MAX, COORD_MIN, 1'b0);
		send_point(24'd5, COORD_MIN, COORD_MAX, 1'b0);
		send_point(24'd5, '0, '0, 1'b1);

		// widest cell, largest grid, opposite corner
		load_grid(COORD_MAX, COORD_MIN, 32'hFFFF_FFFF, 32'hFFFF_F000, 32'h0000_1000);
		send_point(24'd6, COORD_MAX, COORD_MIN, 1'b0);
		send_point(24'd6, COORD_MIN, COORD_MAX, 1'b0);
		send_point(24'd6, '0, COORD_MIN, 1'b1);

		for (int p = 0; p < RANDOM_PHASES; p++)
			random_phase(p % 2 == 1);

		drain();
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
